### design/mvn_pkg.sv
// ----------------------------------------------------------------------------
// mvn_pkg
// Shared types, sizes and helpers of the mesh vertex normal generator.
// ----------------------------------------------------------------------------
package mvn_pkg;

	localparam int NUM_VERTICES = 1024;
	localparam int SUM_WIDTH    = 32;
	localparam int IDX_W        = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
	localparam int CORNER_W     = 10;
	localparam int POS_W        = 16;
	localparam int PROD_W       = 34;
	localparam int CROSS_W      = 35;
	localparam int VEC_W        = (SUM_WIDTH > CROSS_W) ? SUM_WIDTH : CROSS_W;
	localparam int NRM_W        = 16;
	localparam int QDEPTH       = 2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_FACE  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  a;
		logic [IDX_W-1:0]  b;
		logic [IDX_W-1:0]  c;
		logic [POS_W-1:0]  px;
		logic [POS_W-1:0]  py;
		logic [POS_W-1:0]  pz;
	} cmd_t;

	typedef struct packed {
		logic ready;
		logic init_busy;
	} back_stat_t;

	typedef enum logic [3:0] {
		B_INIT, B_IDLE, B_RDA, B_RDB, B_RDC, B_CAPC, B_MUL, B_NGO, B_NWAIT,
		B_ACC_RD, B_ACC_WR, B_SUM_RD, B_SUM_CAP, B_CLR, B_OUT
	} back_state_t;

	typedef enum logic [2:0] {
		N_IDLE, N_SCALE, N_SQ, N_SQRT, N_DIV, N_DONE
	} norm_state_t;

	// Reduce a corner index modulo the store depth by binary long subtraction.
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [CORNER_W-1:0] v);
		int x;
		x = int'(v);
		for (int k = CORNER_W - 1; k >= 0; k--) begin
			if (x >= (NUM_VERTICES << k))
				x = x - (NUM_VERTICES << k);
		end
		return IDX_W'(x);
	endfunction

endpackage

### design/mesh_vertex_normal_generator.sv
// ----------------------------------------------------------------------------
// mesh_vertex_normal_generator
// Face and vertex normal generator over a store of Q8.8 vertex positions.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; a two-word
// queue lets new words in while the back end works. After reset the block is
// busy while it clears the position and sum stores. Most of the work of a
// face or a vertex normal read is in the serial normalizer (up to 22 scaling
// shifts, 3 squares, 24 root steps, 45 divide steps). A zero-length vector
// skips the normalizer steps and finishes much sooner. A clear walks the sum
// store, one entry per cycle.
// Each face or vertex normal appears for one cycle with done high; the
// receiver must take it then.
module mesh_vertex_normal_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic [9:0]                    corner_a,
	input  logic [9:0]                    corner_b,
	input  logic [9:0]                    corner_c,
	input  logic signed [15:0]            pos_x,
	input  logic signed [15:0]            pos_y,
	input  logic signed [15:0]            pos_z,
	output logic                          done,
	output logic signed [15:0]            normal_x,
	output logic signed [15:0]            normal_y,
	output logic signed [15:0]            normal_z,
	output logic                          is_vertex_normal,
	output logic                          status
);

	mvn_pkg::back_stat_t stat;
	mvn_pkg::cmd_t       cmd;
	logic                cmd_valid;

	mvn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.corner_a  (corner_a),
		.corner_b  (corner_b),
		.corner_c  (corner_c),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.stat      (stat),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	mvn_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd              (cmd),
		.stat             (stat),
		.done             (done),
		.normal_x         (normal_x),
		.normal_y         (normal_y),
		.normal_z         (normal_z),
		.is_vertex_normal (is_vertex_normal),
		.status           (status)
	);

endmodule

### design/mvn_front.sv
// ----------------------------------------------------------------------------
// mvn_front
// Command intake: wraps corner indices and queues words for the back end.
// ----------------------------------------------------------------------------
module mvn_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       opcode,
	input  logic [mvn_pkg::CORNER_W-1:0]     corner_a,
	input  logic [mvn_pkg::CORNER_W-1:0]     corner_b,
	input  logic [mvn_pkg::CORNER_W-1:0]     corner_c,
	input  logic [mvn_pkg::POS_W-1:0]        pos_x,
	input  logic [mvn_pkg::POS_W-1:0]        pos_y,
	input  logic [mvn_pkg::POS_W-1:0]        pos_z,
	input  mvn_pkg::back_stat_t              stat,
	output logic                             cmd_valid,
	output mvn_pkg::cmd_t                    cmd
);

	mvn_pkg::cmd_t fifo_q [mvn_pkg::QDEPTH];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          push, pop;
	mvn_pkg::cmd_t in_word;

	// Classify the incoming word
	always_comb begin
		in_word.op = mvn_pkg::op_t'(opcode);
		in_word.a  = mvn_pkg::wrap_idx(corner_a);
		in_word.b  = mvn_pkg::wrap_idx(corner_b);
		in_word.c  = mvn_pkg::wrap_idx(corner_c);
		in_word.px = pos_x;
		in_word.py = pos_y;
		in_word.pz = pos_z;
	end

	assign busy      = (count_q == 2'(mvn_pkg::QDEPTH)) || stat.init_busy;
	assign push      = start && !busy;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && stat.ready;
	assign cmd       = fifo_q[rd_ptr_q];

	// Store the word
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= in_word;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### design/mvn_norm.sv
// ----------------------------------------------------------------------------
// mvn_norm
// Serial normalizer: scale, sum of squares, bit-serial root, serial divide.
// ----------------------------------------------------------------------------
module mvn_norm (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   go,
	input  logic signed [mvn_pkg::VEC_W-1:0]       vx,
	input  logic signed [mvn_pkg::VEC_W-1:0]       vy,
	input  logic signed [mvn_pkg::VEC_W-1:0]       vz,
	output logic                                   idle,
	output logic                                   done,
	output logic [mvn_pkg::NRM_W-1:0]              nx,
	output logic [mvn_pkg::NRM_W-1:0]              ny,
	output logic [mvn_pkg::NRM_W-1:0]              nz,
	output logic                                   zero
);

	localparam int VW = mvn_pkg::VEC_W;

	mvn_pkg::norm_state_t state_q, state_d;
	logic [VW-1:0]  m_q [3];
	logic           neg_q [3];
	logic [VW-1:0]  mx_q;
	logic [47:0]    acc_q;
	logic [47:0]    rad_q;
	logic [25:0]    rem_q;
	logic [23:0]    root_q;
	logic [4:0]     cnt_q;
	logic [1:0]     comp_q;
	logic [37:0]    r_q;
	logic [14:0]    q_q;
	logic [15:0]    n_q [3];
	logic           zero_q;

	logic [VW-1:0]  mag [3];
	logic [VW-1:0]  mx_in;
	logic [45:0]    sq;
	logic [25:0]    rem_sh, trial;
	logic [37:0]    dtrial;
	logic           dtake;
	logic [14:0]    q_new;
	logic [1:0]     comp_nx;
	logic [37:0]    num_nx;

	// Take magnitudes of the inputs
	always_comb begin
		mag[0] = vx[VW-1] ? VW'(-vx) : VW'(vx);
		mag[1] = vy[VW-1] ? VW'(-vy) : VW'(vy);
		mag[2] = vz[VW-1] ? VW'(-vz) : VW'(vz);
		mx_in  = mag[0];
		if (mag[1] > mx_in)
			mx_in = mag[1];
		if (mag[2] > mx_in)
			mx_in = mag[2];
	end

	// Datapath helpers
	always_comb begin
		sq      = m_q[comp_q][22:0] * m_q[comp_q][22:0];
		rem_sh  = {rem_q[23:0], rad_q[47:46]};
		trial   = {root_q, 2'b01};
		dtrial  = 38'(root_q) << cnt_q;
		dtake   = (r_q >= dtrial);
		q_new   = q_q | (15'(dtake) << cnt_q);
		comp_nx = comp_q + 2'd1;
		num_nx  = {1'b0, m_q[comp_nx][22:0], 14'd0} + 38'(root_q[23:1]);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mvn_pkg::N_IDLE:  if (go) state_d = mvn_pkg::N_SCALE;
			mvn_pkg::N_SCALE: begin
				if (mx_q == '0)
					state_d = mvn_pkg::N_DONE;
				else if (mx_q >= VW'(1 << 22) && mx_q < VW'(1 << 23))
					state_d = mvn_pkg::N_SQ;
			end
			mvn_pkg::N_SQ:    if (comp_q == 2'd2) state_d = mvn_pkg::N_SQRT;
			mvn_pkg::N_SQRT:  if (cnt_q == 5'd23) state_d = mvn_pkg::N_DIV;
			mvn_pkg::N_DIV:   if (cnt_q == 5'd0 && comp_q == 2'd2) state_d = mvn_pkg::N_DONE;
			mvn_pkg::N_DONE:  state_d = mvn_pkg::N_IDLE;
			default:          state_d = mvn_pkg::N_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		idle = (state_q == mvn_pkg::N_IDLE);
		done = (state_q == mvn_pkg::N_DONE);
		nx   = n_q[0];
		ny   = n_q[1];
		nz   = n_q[2];
		zero = zero_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mvn_pkg::N_IDLE;
		else
			state_q <= state_d;
	end

	// Work one step per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			mvn_pkg::N_IDLE: begin
				if (go) begin
					m_q[0]   <= mag[0];
					m_q[1]   <= mag[1];
					m_q[2]   <= mag[2];
					neg_q[0] <= vx[VW-1];
					neg_q[1] <= vy[VW-1];
					neg_q[2] <= vz[VW-1];
					mx_q     <= mx_in;
				end
			end
			mvn_pkg::N_SCALE: begin
				comp_q <= 2'd0;
				acc_q  <= '0;
				if (mx_q == '0) begin
					zero_q <= 1'b1;
					n_q[0] <= '0;
					n_q[1] <= '0;
					n_q[2] <= '0;
				end else if (mx_q >= VW'(1 << 23)) begin
					mx_q   <= mx_q >> 1;
					m_q[0] <= m_q[0] >> 1;
					m_q[1] <= m_q[1] >> 1;
					m_q[2] <= m_q[2] >> 1;
				end else if (mx_q < VW'(1 << 22)) begin
					mx_q   <= mx_q << 1;
					m_q[0] <= m_q[0] << 1;
					m_q[1] <= m_q[1] << 1;
					m_q[2] <= m_q[2] << 1;
				end
			end
			mvn_pkg::N_SQ: begin
				acc_q  <= acc_q + 48'(sq);
				comp_q <= comp_nx;
				rad_q  <= acc_q + 48'(sq);
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= 5'd0;
			end
			mvn_pkg::N_SQRT: begin
				rad_q <= rad_q << 2;
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[22:0], 1'b0};
				end
				if (cnt_q == 5'd23) begin
					cnt_q  <= 5'd14;
					comp_q <= 2'd0;
					q_q    <= '0;
					zero_q <= 1'b0;
					r_q    <= {1'b0, m_q[0][22:0], 14'd0} + 38'(root_q[22:0]);
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
			mvn_pkg::N_DIV: begin
				// root_q now holds L; L/2 is root_q[23:1]
				if (cnt_q == 5'd0) begin
					n_q[comp_q] <= neg_q[comp_q] ? -16'(q_new) : 16'(q_new);
					comp_q      <= comp_nx;
					cnt_q       <= 5'd14;
					q_q         <= '0;
					r_q         <= num_nx;
				end else begin
					if (dtake)
						r_q <= r_q - dtrial;
					q_q   <= q_new;
					cnt_q <= cnt_q - 5'd1;
				end
			end
			mvn_pkg::N_DONE: ;
			default: ;
		endcase
	end

endmodule

### design/mvn_back.sv
// ----------------------------------------------------------------------------
// mvn_back
// Command execution: vertex and sum stores, cross product, accumulation.
// ----------------------------------------------------------------------------
module mvn_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	input  mvn_pkg::cmd_t                     cmd,
	output mvn_pkg::back_stat_t               stat,
	output logic                              done,
	output logic [mvn_pkg::NRM_W-1:0]         normal_x,
	output logic [mvn_pkg::NRM_W-1:0]         normal_y,
	output logic [mvn_pkg::NRM_W-1:0]         normal_z,
	output logic                              is_vertex_normal,
	output logic                              status
);

	localparam int IW = mvn_pkg::IDX_W;
	localparam int SW = mvn_pkg::SUM_WIDTH;
	localparam int PW = 3 * mvn_pkg::POS_W;

	mvn_pkg::back_state_t state_q, state_d;
	mvn_pkg::cmd_t        cmd_q;

	logic [PW-1:0]   pos_mem [mvn_pkg::NUM_VERTICES];
	logic [3*SW-1:0] sum_mem [mvn_pkg::NUM_VERTICES];
	logic [PW-1:0]   pos_rd_q;
	logic [3*SW-1:0] sum_rd_q;

	logic [IW:0]     sweep_q;
	logic [2:0]      cnt_q;
	logic [1:0]      k_q;
	logic signed [15:0] pa_q [3];
	logic signed [15:0] pb_q [3];
	logic signed [15:0] pc_q [3];
	logic signed [mvn_pkg::PROD_W-1:0] prod_q [6];
	logic signed [mvn_pkg::VEC_W-1:0]  v_q [3];
	logic [15:0]     n_q [3];
	logic            zero_q;

	logic            pop;
	logic            norm_go, norm_idle, norm_done, norm_zero;
	logic [15:0]     nx, ny, nz;
	logic [IW-1:0]   rd_addr;
	logic            pos_we, sum_we;
	logic [IW-1:0]   wr_addr;
	logic [PW-1:0]   pos_wd;
	logic [3*SW-1:0] sum_wd;
	logic signed [16:0] u [3];
	logic signed [16:0] w [3];
	logic signed [16:0] op_l, op_r;
	logic [IW-1:0]   corner_k;

	assign pop = (state_q == mvn_pkg::B_IDLE) && cmd_valid;

	// Saturating add of one normal component into a sum
	function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic [15:0] d);
		logic signed [SW:0] r;
		r = $signed({s[SW-1], s}) + (SW+1)'($signed(d));
		if (r[SW] != r[SW-1])
			return r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		return r[SW-1:0];
	endfunction

	// Differences and multiplier operand select
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u[i] = 17'(pb_q[i]) - 17'(pa_q[i]);
			w[i] = 17'(pb_q[i]) - 17'(pc_q[i]);
		end
		op_l = u[1];
		op_r = w[2];
		unique case (cnt_q)
			3'd0: begin op_l = u[1]; op_r = w[2]; end
			3'd1: begin op_l = u[2]; op_r = w[1]; end
			3'd2: begin op_l = u[2]; op_r = w[0]; end
			3'd3: begin op_l = u[0]; op_r = w[2]; end
			3'd4: begin op_l = u[0]; op_r = w[1]; end
			3'd5: begin op_l = u[1]; op_r = w[0]; end
			default: begin op_l = u[1]; op_r = w[2]; end
		endcase
		unique case (k_q)
			2'd0:    corner_k = cmd_q.a;
			2'd1:    corner_k = cmd_q.b;
			default: corner_k = cmd_q.c;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mvn_pkg::B_INIT:
				if (sweep_q == (IW+1)'(mvn_pkg::NUM_VERTICES - 1)) state_d = mvn_pkg::B_IDLE;
			mvn_pkg::B_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						mvn_pkg::OP_WRITE: state_d = mvn_pkg::B_IDLE;
						mvn_pkg::OP_FACE:  state_d = mvn_pkg::B_RDA;
						mvn_pkg::OP_READ:  state_d = mvn_pkg::B_SUM_RD;
						mvn_pkg::OP_CLEAR: state_d = mvn_pkg::B_CLR;
					endcase
				end
			end
			mvn_pkg::B_RDA:     state_d = mvn_pkg::B_RDB;
			mvn_pkg::B_RDB:     state_d = mvn_pkg::B_RDC;
			mvn_pkg::B_RDC:     state_d = mvn_pkg::B_CAPC;
			mvn_pkg::B_CAPC:    state_d = mvn_pkg::B_MUL;
			mvn_pkg::B_MUL:     if (cnt_q == 3'd6) state_d = mvn_pkg::B_NGO;
			mvn_pkg::B_NGO:     state_d = mvn_pkg::B_NWAIT;
			mvn_pkg::B_NWAIT: begin
				if (norm_done)
					state_d = (cmd_q.op == mvn_pkg::OP_FACE) ? mvn_pkg::B_ACC_RD : mvn_pkg::B_OUT;
			end
			mvn_pkg::B_ACC_RD:  state_d = mvn_pkg::B_ACC_WR;
			mvn_pkg::B_ACC_WR:  state_d = (k_q == 2'd2) ? mvn_pkg::B_OUT : mvn_pkg::B_ACC_RD;
			mvn_pkg::B_SUM_RD:  state_d = mvn_pkg::B_SUM_CAP;
			mvn_pkg::B_SUM_CAP: state_d = mvn_pkg::B_NGO;
			mvn_pkg::B_CLR:
				if (sweep_q == (IW+1)'(mvn_pkg::NUM_VERTICES - 1)) state_d = mvn_pkg::B_IDLE;
			mvn_pkg::B_OUT:     state_d = mvn_pkg::B_IDLE;
			default:            state_d = mvn_pkg::B_IDLE;
		endcase
	end

	// Outputs and memory controls
	always_comb begin
		stat.ready     = (state_q == mvn_pkg::B_IDLE);
		stat.init_busy = (state_q == mvn_pkg::B_INIT);
		norm_go        = (state_q == mvn_pkg::B_NGO);
		rd_addr = cmd_q.a;
		pos_we  = 1'b0;
		sum_we  = 1'b0;
		wr_addr = sweep_q[IW-1:0];
		pos_wd  = '0;
		sum_wd  = '0;
		unique case (state_q)
			mvn_pkg::B_INIT: begin
				pos_we = 1'b1;
				sum_we = 1'b1;
			end
			mvn_pkg::B_CLR:    sum_we = 1'b1;
			mvn_pkg::B_IDLE: begin
				if (pop && cmd.op == mvn_pkg::OP_WRITE) begin
					pos_we  = 1'b1;
					wr_addr = cmd.a;
					pos_wd  = {cmd.px, cmd.py, cmd.pz};
				end
			end
			mvn_pkg::B_RDA:    rd_addr = cmd_q.a;
			mvn_pkg::B_RDB:    rd_addr = cmd_q.b;
			mvn_pkg::B_RDC:    rd_addr = cmd_q.c;
			mvn_pkg::B_SUM_RD: rd_addr = cmd_q.a;
			mvn_pkg::B_ACC_RD: rd_addr = corner_k;
			mvn_pkg::B_ACC_WR: begin
				sum_we  = 1'b1;
				wr_addr = corner_k;
				sum_wd  = {sat_add(sum_rd_q[3*SW-1:2*SW], n_q[0]),
				           sat_add(sum_rd_q[2*SW-1:SW], n_q[1]),
				           sat_add(sum_rd_q[SW-1:0], n_q[2])};
			end
			default: ;
		endcase
	end

	// Position and sum stores
	always_ff @(posedge clk) begin
		if (pos_we)
			pos_mem[wr_addr] <= pos_wd;
		if (sum_we)
			sum_mem[wr_addr] <= sum_wd;
		pos_rd_q <= pos_mem[rd_addr];
		sum_rd_q <= sum_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mvn_pkg::B_INIT;
			sweep_q <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == mvn_pkg::B_OUT);
			if (state_q == mvn_pkg::B_INIT || state_q == mvn_pkg::B_CLR)
				sweep_q <= sweep_q + (IW+1)'(1);
			else
				sweep_q <= '0;
		end
	end

	// Operation datapath
	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= cmd;
		unique case (state_q)
			mvn_pkg::B_RDB:  for (int i = 0; i < 3; i++) pa_q[i] <= pos_rd_q[PW-1-16*i -: 16];
			mvn_pkg::B_RDC:  for (int i = 0; i < 3; i++) pb_q[i] <= pos_rd_q[PW-1-16*i -: 16];
			mvn_pkg::B_CAPC: begin
				for (int i = 0; i < 3; i++) pc_q[i] <= pos_rd_q[PW-1-16*i -: 16];
				cnt_q <= 3'd0;
			end
			mvn_pkg::B_MUL: begin
				if (cnt_q != 3'd6)
					prod_q[cnt_q] <= mvn_pkg::PROD_W'(op_l * op_r);
				cnt_q <= cnt_q + 3'd1;
			end
			mvn_pkg::B_SUM_CAP: begin
				v_q[0] <= mvn_pkg::VEC_W'($signed(sum_rd_q[3*SW-1:2*SW]));
				v_q[1] <= mvn_pkg::VEC_W'($signed(sum_rd_q[2*SW-1:SW]));
				v_q[2] <= mvn_pkg::VEC_W'($signed(sum_rd_q[SW-1:0]));
			end
			mvn_pkg::B_NWAIT: begin
				k_q <= 2'd0;
				if (norm_done) begin
					n_q[0] <= nx;
					n_q[1] <= ny;
					n_q[2] <= nz;
					zero_q <= norm_zero;
				end
			end
			mvn_pkg::B_ACC_WR: k_q <= k_q + 2'd1;
			default: ;
		endcase
		if (state_q == mvn_pkg::B_MUL && cnt_q == 3'd6) begin
			v_q[0] <= mvn_pkg::VEC_W'($signed(mvn_pkg::CROSS_W'(prod_q[0]) -
			                                  mvn_pkg::CROSS_W'(prod_q[1])));
			v_q[1] <= mvn_pkg::VEC_W'($signed(mvn_pkg::CROSS_W'(prod_q[2]) -
			                                  mvn_pkg::CROSS_W'(prod_q[3])));
			v_q[2] <= mvn_pkg::VEC_W'($signed(mvn_pkg::CROSS_W'(prod_q[4]) -
			                                  mvn_pkg::CROSS_W'(prod_q[5])));
		end
		if (state_q == mvn_pkg::B_OUT) begin
			normal_x         <= n_q[0];
			normal_y         <= n_q[1];
			normal_z         <= n_q[2];
			is_vertex_normal <= (cmd_q.op == mvn_pkg::OP_READ);
			status           <= zero_q;
		end
	end

	mvn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (norm_go),
		.vx     (v_q[0]),
		.vy     (v_q[1]),
		.vz     (v_q[2]),
		.idle   (norm_idle),
		.done   (norm_done),
		.nx     (nx),
		.ny     (ny),
		.nz     (nz),
		.zero   (norm_zero)
	);

	// One result per face or read command, never back to back
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held");
	// Normalizer is only launched when free
	assert property (@(posedge clk) disable iff (!arst_n) norm_go |-> norm_idle)
		else $error("normalizer launched while busy");
	// No command leaves the queue during the reset clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mvn_pkg::B_INIT) |-> !stat.ready)
		else $error("command taken during clearing pass");

endmodule
